FILE: rtl/core/cell_history_revisit_tracker_core_macros.svh
// assertion helpers for the tracker rtl
`ifndef CELL_HISTORY_REVISIT_TRACKER_CORE_MACROS_SVH
`define CELL_HISTORY_REVISIT_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHRT_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/chrt_pkg.sv
package chrt_pkg;

  typedef logic [31:0] entry_t;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [7:0] STILL_LIMIT_RST = 8'd20;

endpackage

FILE: rtl/core/chrt_cell.sv
module chrt_cell import chrt_pkg::*; (
  input  logic   clk_i,
  input  entry_t data_i,
  input  logic   wr_en_i,
  input  entry_t wr_data_i,
  output entry_t data_o
);

  entry_t data_q;
  entry_t data_d;

  // take the neighbor's entry, or a fresh one when written
  assign data_d = wr_en_i ? wr_data_i : data_i;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/cell_history_revisit_tracker_core.sv
// Cell history revisit tracker. An item is taken when start is high and busy is low; its
// single result appears on revisit_o/stuck_o for exactly one cycle with done_o high, and
// the receiver cannot stall it. The history sits in a ring of HISTORY_DEPTH cells that
// rotates one position every cycle, so every stored entry passes the tail cell in turn.
// A query makes one full ring pass, comparing the entries at the tail, before its result.
// An update to a new cell waits for its slot to reach the tail. Updates that stand still,
// clears and unknown functions give their result in the next cycle. busy drops in the
// cycle the result is shown, so a new item can be taken then. still_limit is written
// through the cfg channel, which is always ready.
module cell_history_revisit_tracker_core import chrt_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] cell_x_i,
  input  logic signed [15:0] cell_y_i,
  // result channel
  output logic               done_o,
  output logic               revisit_o,
  output logic               stuck_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEEK = 2'd1;  // waiting for the write slot at the tail
  localparam logic [1:0] ST_SCAN = 2'd2;  // one ring pass for a query

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] tail_idx_q, tail_idx_d;  // logical index held by the tail cell
  logic [IDX_W-1:0] wi_q, wi_d;              // write index
  logic [IDX_W-1:0] cnt_q, cnt_d;            // scan position
  logic [15:0]      last_x_q, last_x_d;
  logic [15:0]      last_y_q, last_y_d;
  logic [7:0]       still_q, still_d;
  logic [7:0]       limit_q, limit_d;
  logic             hit_q, hit_d;
  entry_t           key_q, key_d;
  logic             done_q, done_d;
  logic             revisit_q, revisit_d;
  logic             stuck_q, stuck_d;

  logic             accept;
  logic             moving;
  logic [8:0]       still_inc;
  logic             still_over;
  logic             wr_en;
  logic [IDX_W-1:0] wi_next;
  logic             tail_in_range;
  logic             tail_hit;
  entry_t           cell_in;
  entry_t           ring [HISTORY_DEPTH];

  // ---------------------------------------------------------------------------
  // ring of history cells, tail feeds cell zero, cell zero takes new entries
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      chrt_cell u_cell (
        .clk_i     (clk_i),
        .data_i    (ring[HISTORY_DEPTH-1]),
        .wr_en_i   (wr_en),
        .wr_data_i (key_q),
        .data_o    (ring[g])
      );
    end else begin : g_body
      chrt_cell u_cell (
        .clk_i     (clk_i),
        .data_i    (ring[g-1]),
        .wr_en_i   (1'b0),
        .wr_data_i (key_q),
        .data_o    (ring[g])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign cell_in    = {cell_y_i, cell_x_i};
  assign moving     = (cell_x_i != last_x_q) || (cell_y_i != last_y_q);
  assign still_inc  = {1'b0, still_q} + 9'd1;
  assign still_over = still_inc > {1'b0, limit_q};

  // entry passing the tail is written when its slot matches the write index
  assign wr_en   = (state_q == ST_SEEK) && (tail_idx_q == wi_q);
  assign wi_next = (wi_q == IDX_LAST) ? '0 : wi_q + 1'b1;

  // only entries below write index minus one take part in a query
  assign tail_in_range = ({1'b0, tail_idx_q} + 1'b1) < {1'b0, wi_q};
  assign tail_hit      = tail_in_range && (ring[HISTORY_DEPTH-1] == key_q);

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    tail_idx_d = (tail_idx_q == IDX_LAST) ? '0 : tail_idx_q + 1'b1;
    wi_d       = wi_q;
    cnt_d      = cnt_q;
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    still_d    = still_q;
    limit_d    = limit_q;
    hit_d      = hit_q;
    key_d      = key_q;
    done_d     = 1'b0;
    revisit_d  = revisit_q;
    stuck_d    = stuck_q;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = cell_in;
          case (func_i)
            FUNC_UPDATE: begin
              last_x_d = cell_x_i;
              last_y_d = cell_y_i;
              if (moving) begin
                state_d = ST_SEEK;
              end else begin
                done_d    = 1'b1;
                revisit_d = 1'b0;
                stuck_d   = still_over;
                still_d   = still_over ? 8'd0 : still_inc[7:0];
              end
            end
            FUNC_QUERY: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
              hit_d   = 1'b0;
            end
            FUNC_CLEAR: begin
              wi_d      = '0;
              done_d    = 1'b1;
              revisit_d = 1'b0;
              stuck_d   = 1'b0;
            end
            default: begin
              done_d    = 1'b1;
              revisit_d = 1'b0;
              stuck_d   = 1'b0;
            end
          endcase
        end
      end
      ST_SEEK: begin
        if (wr_en) begin
          wi_d      = wi_next;
          still_d   = 8'd0;
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          revisit_d = 1'b0;
          stuck_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || tail_hit;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IDX_LAST) begin
          state_d   = ST_IDLE;
          done_d    = 1'b1;
          revisit_d = hit_q || tail_hit;
          stuck_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tail_idx_q <= '0;
      wi_q       <= '0;
      cnt_q      <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
      still_q    <= '0;
      limit_q    <= STILL_LIMIT_RST;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      revisit_q  <= 1'b0;
      stuck_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      tail_idx_q <= tail_idx_d;
      wi_q       <= wi_d;
      cnt_q      <= cnt_d;
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
      still_q    <= still_d;
      limit_q    <= limit_d;
      hit_q      <= hit_d;
      done_q     <= done_d;
      revisit_q  <= revisit_d;
      stuck_q    <= stuck_d;
    end
  end

  // search key is payload only
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign done_o    = done_q;
  assign revisit_o = revisit_q;
  assign stuck_o   = stuck_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`include "cell_history_revisit_tracker_core_macros.svh"

  `CHRT_ASSERT(a_one_flag, done_o, !(revisit_o && stuck_o), "both result flags set")
  `CHRT_ASSERT_NEXT(a_accept_progress, accept, busy || done_o, "accepted item dropped")
  `CHRT_ASSERT_NEXT(a_scan_end, (state_q == ST_SCAN) && (cnt_q == IDX_LAST), done_o && !busy, "query pass did not end")
  `CHRT_ASSERT(a_stuck_src, done_o && stuck_o, ($past(accept) && ($past(func_i) == FUNC_UPDATE)), "stuck without a still update")
  `CHRT_ASSERT(a_wi_range, busy, ({1'b0, wi_q} < (IDX_W + 1)'(HISTORY_DEPTH)), "write index out of range")

endmodule
